### rtl/core/packed_string_table_decoder_defines.svh
// Assertion macros for the packed string table decoder.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef PACKED_STRING_TABLE_DECODER_DEFINES_SVH
`define PACKED_STRING_TABLE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge.
`define PSTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle implies a condition in the next cycle.
`define PSTD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define PSTD_ASSERT(lbl, prop, msg)
`define PSTD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### rtl/core/pstd_pkg.sv
package pstd_pkg;

    // String count limit of the decoder
    localparam int MAX_STRINGS = 1024;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int SYM_W  = 5;
    localparam int LIT_W  = 7;
    localparam int STR_W  = 10;

    // Bit window: held bits plus one new byte
    localparam int HELD_W = 4;
    localparam int BUF_W  = 15;
    localparam int WIN_W  = BUF_W + BYTE_W;
    localparam int AVL_W  = 5;

    // Field extraction slots per byte and results per byte
    localparam int SLOTS   = 4;
    localparam int RES_MAX = 2;

    // Output queue depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Decode phases
    localparam logic [2:0] PH_LENGTH = 3'd0;
    localparam logic [2:0] PH_SYMBOL = 3'd1;
    localparam logic [2:0] PH_ONCE   = 3'd2;
    localparam logic [2:0] PH_FLIP   = 3'd3;
    localparam logic [2:0] PH_SEVEN  = 3'd4;

    // Symbol codes
    localparam logic [4:0] SYM_LETTERS    = 5'd26;
    localparam logic [4:0] SYM_UNDERSCORE = 5'd26;
    localparam logic [4:0] SYM_FF         = 5'd27;
    localparam logic [4:0] SYM_ONCE       = 5'd29;
    localparam logic [4:0] SYM_FLIP       = 5'd30;
    localparam logic [4:0] SYM_LITERAL    = 5'd31;

    // Character values
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_FF         = 8'hFF;
    localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
    localparam logic [7:0] CASE_OFFSET     = 8'd32;

    localparam logic [STR_W-1:0] STRING_TOTAL_RESET = 10'd1023;

    typedef struct packed {
        logic [2:0]       phase;
        logic [4:0]       chars_left;
        logic             lower_case;
        logic [STR_W-1:0] current_string;
        logic             first_is_ff;
        logic             first_pending;
    } dec_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] char_code;
        logic [STR_W-1:0]  string_index;
        logic              last_char;
        logic              empty_string;
        logic              internal_key;
    } result_t;

    typedef struct packed {
        dec_state_t st;
        logic       emit;
        result_t    res;
    } field_out_t;

endpackage

### rtl/core/packed_string_table_decoder.sv
// Packed string table decoder. Takes one byte of packed string data per transfer on the
// s_axis side (read MSB first) and gives one decoded character per transfer on the m_axis
// side, with its string index, a last flag on tlast and the empty/internal flags on tuser.
// A string is a 5-bit length, then the codes of that many characters; an empty string gives
// a single result flagged empty. A byte is taken every cycle as long as the 4-entry output
// queue has room for two results. A byte yields up to two results while the output side
// takes at most one result per cycle, so a stream that yields more results than bytes is
// held back by the output side. A byte waits in the input register until the queue
// has room. cfg_wdata written with cfg_we sets how many strings are decoded; once that count
// is reached further bytes are taken and dropped, with the held bits kept so that a larger
// count resumes decoding. At most 15 unused bits are carried between bytes.
`include "packed_string_table_decoder_defines.svh"

module packed_string_table_decoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic [pstd_pkg::STR_W-1:0]   cfg_wdata,      // string_total
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] packed_byte
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,   // [7:0] char_code, [17:8] string_index
    output logic                         m_axis_tlast,   // last_char
    output logic [1:0]                   m_axis_tuser    // [0] empty_string, [1] internal_key
);

    // ------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------
    function automatic logic decoding(input logic [pstd_pkg::STR_W-1:0] cur,
                                      input logic [pstd_pkg::STR_W-1:0] total);
        return (cur < total) && (32'(cur) < pstd_pkg::MAX_STRINGS);
    endfunction

    function automatic logic [7:0] letter(input logic [4:0] v, input logic lower);
        return 8'(v) + pstd_pkg::CHAR_UPPER_A + (lower ? pstd_pkg::CASE_OFFSET : 8'd0);
    endfunction

    function automatic pstd_pkg::dec_state_t finish(input pstd_pkg::dec_state_t st);
        pstd_pkg::dec_state_t ns;
        ns                = st;
        ns.current_string = st.current_string + 1'b1;
        ns.phase          = pstd_pkg::PH_LENGTH;
        ns.chars_left     = 5'd0;
        ns.lower_case     = 1'b1;
        ns.first_pending  = 1'b0;
        return ns;
    endfunction

    // One field through the decode state machine
    function automatic pstd_pkg::field_out_t decode_field(input pstd_pkg::dec_state_t st,
                                                          input logic [6:0] v);
        pstd_pkg::field_out_t fo;
        logic [7:0]           c;
        logic                 is_char;
        logic [4:0]           left;
        logic [4:0]           sym;
        fo.st   = st;
        fo.emit = 1'b0;
        fo.res  = '0;
        c       = 8'd0;
        is_char = 1'b0;
        left    = st.chars_left - 1'b1;
        sym     = v[4:0];
        unique case (st.phase)
            pstd_pkg::PH_LENGTH:
            begin
                if (sym == 5'd0)
                begin
                    fo.emit              = 1'b1;
                    fo.res.char_code     = 8'd0;
                    fo.res.string_index  = st.current_string;
                    fo.res.last_char     = 1'b1;
                    fo.res.empty_string  = 1'b1;
                    fo.res.internal_key  = 1'b0;
                    fo.st                = finish(st);
                end
                else
                begin
                    fo.st.chars_left    = sym;
                    fo.st.lower_case    = 1'b1;
                    fo.st.first_pending = 1'b1;
                    fo.st.first_is_ff   = 1'b0;
                    fo.st.phase         = pstd_pkg::PH_SYMBOL;
                end
            end
            pstd_pkg::PH_SYMBOL:
            begin
                priority if (sym < pstd_pkg::SYM_LETTERS)
                begin
                    is_char = 1'b1;
                    c       = letter(sym, st.lower_case);
                end
                else if (sym == pstd_pkg::SYM_UNDERSCORE)
                begin
                    is_char = 1'b1;
                    c       = pstd_pkg::CHAR_UNDERSCORE;
                end
                else if (sym == pstd_pkg::SYM_FF)
                begin
                    is_char = 1'b1;
                    c       = pstd_pkg::CHAR_FF;
                end
                else if (sym == pstd_pkg::SYM_ONCE)
                begin
                    fo.st.phase = pstd_pkg::PH_ONCE;
                end
                else if (sym == pstd_pkg::SYM_FLIP)
                begin
                    fo.st.lower_case = ~st.lower_case;
                    fo.st.phase      = pstd_pkg::PH_FLIP;
                end
                else if (sym == pstd_pkg::SYM_LITERAL)
                begin
                    fo.st.phase = pstd_pkg::PH_SEVEN;
                end
                else
                begin
                    // symbol 28 passes through as the byte itself
                    is_char = 1'b1;
                    c       = 8'(sym);
                end
            end
            pstd_pkg::PH_ONCE:
            begin
                is_char = 1'b1;
                c       = letter(sym, ~st.lower_case);
            end
            pstd_pkg::PH_FLIP:
            begin
                is_char = 1'b1;
                c       = letter(sym, st.lower_case);
            end
            default:
            begin
                // 7-bit literal
                is_char = 1'b1;
                c       = 8'(v);
            end
        endcase

        // character emit: first-char tracking, count down, close string
        if (is_char)
        begin
            if (st.first_pending)
            begin
                fo.st.first_is_ff   = (c == pstd_pkg::CHAR_FF);
                fo.st.first_pending = 1'b0;
            end
            fo.st.chars_left    = left;
            fo.emit             = 1'b1;
            fo.res.char_code    = c;
            fo.res.string_index = st.current_string;
            fo.res.last_char    = (left == 5'd0);
            fo.res.empty_string = 1'b0;
            fo.res.internal_key = fo.st.first_is_ff;
            if (left == 5'd0)
            begin
                fo.st = finish(fo.st);
            end
            else
            begin
                fo.st.phase = pstd_pkg::PH_SYMBOL;
            end
        end
        return fo;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [pstd_pkg::STR_W-1:0]   total_reg;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [pstd_pkg::BYTE_W-1:0]  in_byte_reg;

    pstd_pkg::dec_state_t         st_reg;
    pstd_pkg::dec_state_t         st_next;
    logic [pstd_pkg::BUF_W-1:0]   bitbuf_reg;
    logic [pstd_pkg::BUF_W-1:0]   bitbuf_next;
    logic [pstd_pkg::HELD_W-1:0]  held_reg;
    logic [pstd_pkg::HELD_W-1:0]  held_next;

    pstd_pkg::result_t            fifo_mem [pstd_pkg::FIFO_DEPTH];
    logic [pstd_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [pstd_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [pstd_pkg::FIFO_CW-1:0] cnt_reg;
    logic [pstd_pkg::FIFO_CW-1:0] cnt_next;

    logic                         s_xfer;
    logic                         m_xfer;
    logic                         proc;
    logic                         start_dec;
    logic                         step_open;

    logic [pstd_pkg::WIN_W-1:0]   win;
    logic [pstd_pkg::WIN_W-1:0]   win_shift;
    logic [pstd_pkg::WIN_W-1:0]   win_mask;
    logic [pstd_pkg::AVL_W-1:0]   avail;
    logic [pstd_pkg::AVL_W-1:0]   need;
    logic [6:0]                   field_val;
    pstd_pkg::dec_state_t         st_work;
    pstd_pkg::field_out_t         fo;
    pstd_pkg::result_t            res_out [pstd_pkg::RES_MAX];
    logic [1:0]                   res_cnt;
    logic [1:0]                   push_cnt;
    pstd_pkg::result_t            head;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign proc          = in_valid_reg && (cnt_reg <= pstd_pkg::FIFO_CW'(pstd_pkg::RES_MAX));
    assign s_axis_tready = !in_valid_reg || proc;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_xfer        = m_axis_tvalid && m_axis_tready;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= pstd_pkg::STRING_TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            total_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Field extraction: up to SLOTS fields from the bit window per byte
    // ------------------------------------------------------------------
    assign start_dec = decoding(st_reg.current_string, total_reg);
    assign win       = {bitbuf_reg, in_byte_reg};

    always_comb
    begin
        st_work    = st_reg;
        avail      = pstd_pkg::AVL_W'(held_reg) + pstd_pkg::AVL_W'(pstd_pkg::BYTE_W);
        res_cnt    = 2'd0;
        res_out[0] = '0;
        res_out[1] = '0;
        need       = '0;
        win_shift  = '0;
        field_val  = '0;
        fo         = '0;
        for (int s = 0; s < pstd_pkg::SLOTS; s++)
        begin
            need = (st_work.phase == pstd_pkg::PH_SEVEN) ?
                   pstd_pkg::AVL_W'(pstd_pkg::LIT_W) : pstd_pkg::AVL_W'(pstd_pkg::SYM_W);
            if (start_dec && (res_cnt < 2'(pstd_pkg::RES_MAX)) &&
                decoding(st_work.current_string, total_reg) && (avail >= need))
            begin
                win_shift = win >> (avail - need);
                field_val = (st_work.phase == pstd_pkg::PH_SEVEN) ?
                            win_shift[6:0] : {2'b00, win_shift[4:0]};
                fo        = decode_field(st_work, field_val);
                st_work   = fo.st;
                avail     = avail - need;
                if (fo.emit)
                begin
                    res_out[res_cnt[0]] = fo.res;
                    res_cnt             = res_cnt + 2'd1;
                end
            end
        end
    end

    // keep the unused low bits of the window
    assign win_mask = (pstd_pkg::WIN_W'(1) << avail) - pstd_pkg::WIN_W'(1);

    always_comb
    begin
        if (start_dec)
        begin
            st_next     = st_work;
            bitbuf_next = pstd_pkg::BUF_W'(win & win_mask);
            held_next   = avail[pstd_pkg::HELD_W-1:0];
        end
        else
        begin
            st_next     = st_reg;
            bitbuf_next = bitbuf_reg;
            held_next   = held_reg;
        end
    end

    assign step_open = proc && start_dec && decoding(st_next.current_string, total_reg) &&
                       (res_cnt < 2'(pstd_pkg::RES_MAX));

    // ------------------------------------------------------------------
    // Decode state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase          <= pstd_pkg::PH_LENGTH;
            st_reg.chars_left     <= 5'd0;
            st_reg.lower_case     <= 1'b1;
            st_reg.current_string <= '0;
            st_reg.first_is_ff    <= 1'b0;
            st_reg.first_pending  <= 1'b0;
            bitbuf_reg            <= '0;
            held_reg              <= '0;
        end
        else if (proc)
        begin
            st_reg     <= st_next;
            bitbuf_reg <= bitbuf_next;
            held_reg   <= held_next;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: up to two writes, one read per cycle
    // ------------------------------------------------------------------
    assign push_cnt = proc ? res_cnt : 2'd0;
    assign cnt_next = cnt_reg + pstd_pkg::FIFO_CW'(push_cnt) - pstd_pkg::FIFO_CW'(m_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + pstd_pkg::FIFO_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + pstd_pkg::FIFO_AW'(m_xfer);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res_out[0];
        end
        if (push_cnt == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= res_out[1];
        end
    end

    // ------------------------------------------------------------------
    // Output mapping
    // ------------------------------------------------------------------
    assign head         = fifo_mem[rd_ptr_reg];
    assign m_axis_tdata = {6'd0, head.string_index, head.char_code};
    assign m_axis_tlast = head.last_char;
    assign m_axis_tuser = {head.internal_key, head.empty_string};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSTD_ASSERT(a_fifo_bound, cnt_reg <= pstd_pkg::FIFO_CW'(pstd_pkg::FIFO_DEPTH), "output queue overflow")
    `PSTD_ASSERT_NEXT(a_fifo_hold, !proc && !m_xfer, $stable(cnt_reg), "queue count moved without a transfer")
    `PSTD_ASSERT_NEXT(a_held_drained, step_open, held_reg < pstd_pkg::HELD_W'(pstd_pkg::LIT_W), "full field left unread")

endmodule

### tb/sv/string_decode_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels and the config port. Predicts the decoded
// characters for every accepted byte and compares each output transfer with them.
module string_decode_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pstd_pkg::STR_W-1:0] cfg_wdata,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [23:0]                m_axis_tdata,
    input  logic                       m_axis_tlast,
    input  logic [1:0]                 m_axis_tuser,
    output int                         fail_count,
    output int                         pending_chars,
    output int                         chars_checked
);
    import pstd_pkg::*;

    localparam int PRINT_LIMIT = 40;

    // Predictor copy of the decoder state
    logic [STR_W-1:0] string_limit;
    int unsigned      window_bits;
    int unsigned      window_len;
    logic [2:0]       decode_phase;
    logic [4:0]       chars_left;
    bit               lower_case;
    bit               first_is_ff;
    bit               first_pending;
    int unsigned      string_idx;

    // Decoded characters still owed by the block, oldest first
    result_t expected_chars[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic bit still_decoding();
        return string_idx < string_limit && string_idx < MAX_STRINGS;
    endfunction

    // Letter code with 8-bit wrap; operands above 25 are not range-checked
    function automatic logic [7:0] letter_code(input logic [4:0] v, input bit lower);
        return {3'b000, v} + CHAR_UPPER_A + (lower ? CASE_OFFSET : 8'd0);
    endfunction

    task automatic expect_result(input logic [7:0] code, input bit last, input bit empty,
                                 input bit internal);
        result_t r;
        r.char_code    = code;
        r.string_index = string_idx[STR_W-1:0];
        r.last_char    = last;
        r.empty_string = empty;
        r.internal_key = internal;
        expected_chars.push_back(r);
    endtask

    task automatic close_string();
        string_idx++;
        decode_phase  = PH_LENGTH;
        chars_left    = '0;
        lower_case    = 1'b1;
        first_pending = 1'b0;
    endtask

    task automatic decode_char(input logic [7:0] code);
        bit last;
        if (first_pending)
        begin
            first_is_ff   = (code == CHAR_FF);
            first_pending = 1'b0;
        end
        chars_left = chars_left - 5'd1;
        last = (chars_left == 5'd0);
        expect_result(code, last, 1'b0, first_is_ff);
        if (last)
            close_string();
        else
            decode_phase = PH_SYMBOL;
    endtask

    // One accepted byte: if the string count is not reached, append it to the window and
    // pull fields until two results are out, bits run short or the string count is reached.
    task automatic decode_byte(input logic [7:0] b);
        int          made;
        int unsigned need;
        int unsigned v;
        bit          starved;
        made    = 0;
        starved = 1'b0;
        if (still_decoding())
        begin
            window_bits = (window_bits << 8) | b;
            window_len  = window_len + 8;
            window_bits = window_bits & ((1 << window_len) - 1);
            while (!starved && made < RES_MAX && still_decoding())
            begin
                need = (decode_phase == PH_SEVEN) ? LIT_W : SYM_W;
                if (window_len < need)
                    starved = 1'b1;
                else
                begin
                    v = (window_bits >> (window_len - need)) & ((1 << need) - 1);
                    window_len  = window_len - need;
                    window_bits = window_bits & ((1 << window_len) - 1);
                    case (decode_phase)
                        PH_LENGTH:
                        begin
                            if (v == 0)
                            begin
                                expect_result(8'h00, 1'b1, 1'b1, 1'b0);
                                made++;
                                close_string();
                            end
                            else
                            begin
                                chars_left    = v[4:0];
                                lower_case    = 1'b1;
                                first_pending = 1'b1;
                                first_is_ff   = 1'b0;
                                decode_phase  = PH_SYMBOL;
                            end
                        end
                        PH_SYMBOL:
                        begin
                            if (v < SYM_LETTERS)
                            begin
                                decode_char(letter_code(v[4:0], lower_case));
                                made++;
                            end
                            else if (v == SYM_UNDERSCORE)
                            begin
                                decode_char(CHAR_UNDERSCORE);
                                made++;
                            end
                            else if (v == SYM_FF)
                            begin
                                decode_char(CHAR_FF);
                                made++;
                            end
                            else if (v == SYM_ONCE)
                                decode_phase = PH_ONCE;
                            else if (v == SYM_FLIP)
                            begin
                                lower_case   = !lower_case;
                                decode_phase = PH_FLIP;
                            end
                            else if (v == SYM_LITERAL)
                                decode_phase = PH_SEVEN;
                            else
                            begin
                                // the remaining symbol passes through as its own byte
                                decode_char(v[7:0]);
                                made++;
                            end
                        end
                        PH_ONCE:
                        begin
                            decode_char(letter_code(v[4:0], !lower_case));
                            made++;
                        end
                        PH_FLIP:
                        begin
                            decode_char(letter_code(v[4:0], lower_case));
                            made++;
                        end
                        default:
                        begin
                            decode_char(v[7:0]);
                            made++;
                        end
                    endcase
                end
            end
        end
    endtask

    // Compare one output transfer with the oldest expected character
    task automatic check_char();
        result_t want;
        if (expected_chars.size() == 0)
            report_mismatch("result with nothing expected", m_axis_tdata, 32'h0);
        else
        begin
            want = expected_chars.pop_front();
            if (m_axis_tdata[7:0] !== want.char_code)
                report_mismatch($sformatf("char_code of string %0d", want.string_index),
                                m_axis_tdata[7:0], want.char_code);
            if (m_axis_tdata[17:8] !== want.string_index)
                report_mismatch("string_index", m_axis_tdata[17:8], want.string_index);
            if (m_axis_tlast !== want.last_char)
                report_mismatch($sformatf("last_char of string %0d", want.string_index),
                                m_axis_tlast, want.last_char);
            if (m_axis_tuser[0] !== want.empty_string)
                report_mismatch($sformatf("empty_string of string %0d", want.string_index),
                                m_axis_tuser[0], want.empty_string);
            if (m_axis_tuser[1] !== want.internal_key)
                report_mismatch($sformatf("internal_key of string %0d", want.string_index),
                                m_axis_tuser[1], want.internal_key);
        end
        chars_checked++;
    endtask

    // Output side first so a character predicted at this edge cannot pair up
    // with a transfer that left the block at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_limit  = STRING_TOTAL_RESET;
            window_bits   = 0;
            window_len    = 0;
            decode_phase  = PH_LENGTH;
            chars_left    = '0;
            lower_case    = 1'b1;
            first_is_ff   = 1'b0;
            first_pending = 1'b0;
            string_idx    = 0;
            fail_count    = 0;
            chars_checked = 0;
            expected_chars.delete();
            pending_chars <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_char();
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (cfg_we)
                string_limit = cfg_wdata;
            pending_chars <= expected_chars.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pstd_pkg::*;

    localparam int         BYTE_BUDGET      = 1700;
    localparam int         NOISE_BYTES      = 150;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         CYCLE_LIMIT      = 1000000;
    localparam int         DIRECTED_STRINGS = 12;
    localparam logic [4:0] SYM_RAW          = 5'd28;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int pending_chars;
    int chars_checked;

    // Packed bit stream waiting to go out, MSB of each byte first
    bit stream_bits[$];
    int string_end_pos[$];
    int bits_queued    = 0;
    int bits_sent      = 0;
    int bytes_sent     = 0;
    int strings_queued = 0;
    bit src_calm       = 1'b0;
    int cycle_count    = 0;

    packed_string_table_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    string_decode_checker char_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_chars (pending_chars),
        .chars_checked (chars_checked)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("packed_string_table_decoder verification failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(12, 40);
    endfunction

    // ---------------------------------------------------------------
    // Stream building
    // ---------------------------------------------------------------
    task automatic push_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            stream_bits.push_back(v[i]);
        bits_queued += n;
    endtask

    task automatic end_string();
        string_end_pos.push_back(bits_queued);
        strings_queued++;
    endtask

    // Letter operand after a case prefix, sometimes past the alphabet
    task automatic queue_operand();
        push_bits(($urandom_range(0, 9) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25),
                  SYM_W);
    endtask

    task automatic queue_symbol(input bit first);
        int r;
        r = $urandom_range(0, 99);
        if (first && $urandom_range(0, 7) == 0)
            r = 65;
        if (r < 52)
            push_bits($urandom_range(0, 25), SYM_W);
        else if (r < 60)
            push_bits(SYM_UNDERSCORE, SYM_W);
        else if (r < 68)
            push_bits(SYM_FF, SYM_W);
        else if (r < 71)
            push_bits(SYM_RAW, SYM_W);
        else if (r < 79)
        begin
            push_bits(SYM_ONCE, SYM_W);
            queue_operand();
        end
        else if (r < 87)
        begin
            push_bits(SYM_FLIP, SYM_W);
            queue_operand();
        end
        else
        begin
            push_bits(SYM_LITERAL, SYM_W);
            push_bits($urandom_range(0, 127), LIT_W);
        end
    endtask

    task automatic queue_random_string();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 12)
            len = 0;
        else if (r < 80)
            len = $urandom_range(1, 6);
        else if (r < 95)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 31);
        push_bits(len, SYM_W);
        for (int i = 0; i < len; i++)
            queue_symbol(i == 0);
        end_string();
    endtask

    task automatic queue_directed_strings();
        // empty string
        push_bits(0, SYM_W);
        end_string();
        // single lower-case letter
        push_bits(1, SYM_W);
        push_bits(0, SYM_W);
        end_string();
        // last letter, underscore, raw symbol 28
        push_bits(3, SYM_W);
        push_bits(25, SYM_W);
        push_bits(SYM_UNDERSCORE, SYM_W);
        push_bits(SYM_RAW, SYM_W);
        end_string();
        // 0xFF first: internal key
        push_bits(2, SYM_W);
        push_bits(SYM_FF, SYM_W);
        push_bits(0, SYM_W);
        end_string();
        // one-shot upper case, then back to lower
        push_bits(2, SYM_W);
        push_bits(SYM_ONCE, SYM_W);
        push_bits(0, SYM_W);
        push_bits(1, SYM_W);
        end_string();
        // flip to upper for good, then one-shot lower
        push_bits(2, SYM_W);
        push_bits(SYM_FLIP, SYM_W);
        push_bits(25, SYM_W);
        push_bits(SYM_ONCE, SYM_W);
        push_bits(2, SYM_W);
        end_string();
        // literals at both ends of the range
        push_bits(1, SYM_W);
        push_bits(SYM_LITERAL, SYM_W);
        push_bits(7'h7F, LIT_W);
        end_string();
        push_bits(1, SYM_W);
        push_bits(SYM_LITERAL, SYM_W);
        push_bits(7'h00, LIT_W);
        end_string();
        // case prefixes followed by operands past the alphabet
        push_bits(2, SYM_W);
        push_bits(SYM_ONCE, SYM_W);
        push_bits(31, SYM_W);
        push_bits(SYM_FLIP, SYM_W);
        push_bits(30, SYM_W);
        end_string();
        // run of empty strings
        for (int i = 0; i < 3; i++)
        begin
            push_bits(0, SYM_W);
            end_string();
        end
    endtask

    // ---------------------------------------------------------------
    // Channel driving
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream_byte();
        logic [7:0] b;
        while (stream_bits.size() < 8)
            queue_random_string();
        for (int i = 7; i >= 0; i--)
            b[i] = stream_bits.pop_front();
        bits_sent += 8;
        send_byte(b);
    endtask

    // Send bytes up to the one that closes string target-1, and no further,
    // so no byte is dropped and the stream stays aligned across phases
    task automatic run_to_string(input int target);
        while (strings_queued < target)
            queue_random_string();
        while (bits_sent < string_end_pos[target - 1])
            send_stream_byte();
    endtask

    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [9:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Downstream ready: bursts of acceptance broken by stalls
    initial
    begin
        int run_len;
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int target;
        int prev_target;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero string count: every byte is dropped
        write_total(10'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        drain_idle();

        // directed strings, first a count of one
        queue_directed_strings();
        write_total(10'd1);
        run_to_string(1);
        drain_idle();
        write_total(DIRECTED_STRINGS);
        run_to_string(DIRECTED_STRINGS);
        drain_idle();

        // random strings in phases of rising string count
        prev_target = DIRECTED_STRINGS;
        while (bytes_sent < BYTE_BUDGET && prev_target < 900)
        begin
            target   = prev_target + $urandom_range(8, 60);
            src_calm = ($urandom_range(0, 3) == 0);
            write_total(target);
            run_to_string(target);
            drain_idle();
            prev_target = target;
        end
        src_calm = 1'b0;

        // resume, then lower the count while a string is likely half read
        write_total(prev_target + 5);
        send_stream_byte();
        send_stream_byte();
        drain_idle();
        write_total(prev_target);
        repeat (4) send_byte($urandom_range(0, 255));
        drain_idle();

        // full count again: held bits resume against unaligned random bytes
        write_total(STRING_TOTAL_RESET);
        repeat (NOISE_BYTES) send_byte($urandom_range(0, 255));
        drain_idle();

        $display("Sent %0d packed bytes over string counts 0, 1 and up to %0d, incl. a stop mid-string.",
                 bytes_sent, STRING_TOTAL_RESET);
        $display("Compared %0d decoded characters against the prediction.", chars_checked);
        if (pending_chars != 0)
            $display("%0d expected characters never came out", pending_chars);
        if (fail_count == 0 && pending_chars == 0)
            $display("packed_string_table_decoder verification clean");
        else
            $display("packed_string_table_decoder verification failed");
        $finish;
    end

endmodule
